// ----- rtl/i64dr_pkg.sv -----
// ----------------------------------------------------------------------------
// i64dr_pkg
// Shared widths, defaults and operation codes for the pipelined divider.
// ----------------------------------------------------------------------------
package i64dr_pkg;

  // Fixed width of the operand and result ports
  localparam int unsigned DATA_W = 64;

  // Default working width of the divider core
  localparam int unsigned DEF_WIDTH = 64;

  // Operation select codes
  typedef enum logic [1:0] {
    MODE_UQUO = 2'd0,
    MODE_UREM = 2'd1,
    MODE_SQUO = 2'd2,
    MODE_SREM = 2'd3
  } mode_t;

endpackage

// ----- rtl/int64_divide_remainder.sv -----
// ----------------------------------------------------------------------------
// int64_divide_remainder
// Fully pipelined restoring divider: unsigned or signed quotient/remainder,
// one quotient bit resolved per pipeline stage.
// ----------------------------------------------------------------------------
//
//  Channel  Signals                                        Dir  Beat
//  -------  ---------------------------------------------  ---  ------------------
//  in_      in_valid, in_ready, in_dividend, in_divisor,   in   one division
//           in_mode
//  out_     out_valid, out_ready, out_result               out  one result
//
//  An accepted beat passes one stage for operand magnitudes, WIDTH stages of
//  trial subtraction (one quotient bit each, a WIDTH+1 bit subtract per
//  stage), then sign fix-up into the output buffer, which drives out_valid.
//  One beat is taken per cycle, sustained while the skid is empty.
//  Reset clears the stage valid bits and the output buffer flags only.
//  Stalls: the output side is a two-entry buffer (output register plus skid).
//  in_ready comes straight from the skid flag, so the pipe keeps moving while
//  a result waits and only freezes once a second result is parked.
//
//  Division by zero gives an all-ones quotient and the dividend as remainder,
//  then the usual sign fix-ups. The most negative value is its own magnitude.
// ----------------------------------------------------------------------------
module int64_divide_remainder #(
  parameter int unsigned WIDTH = i64dr_pkg::DEF_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [i64dr_pkg::DATA_W-1:0]  in_dividend,
  input  logic [i64dr_pkg::DATA_W-1:0]  in_divisor,
  input  logic [1:0]                    in_mode,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [i64dr_pkg::DATA_W-1:0]  out_result
);

  // --------------------------------------------------------------------------
  // Pipeline storage. Index 0 is the magnitude stage, 1..WIDTH the bit stages.
  // nq holds the dividend bits still to be consumed in its top end and the
  // quotient bits already resolved in its bottom end.
  // --------------------------------------------------------------------------
  logic [WIDTH:0]   v_r;
  logic [WIDTH-1:0] rem_r    [0:WIDTH];
  logic [WIDTH-1:0] nq_r     [0:WIDTH];
  logic [WIDTH-1:0] d_r      [0:WIDTH];
  logic             selrem_r [0:WIDTH];
  logic             neg_r    [0:WIDTH];

  logic [WIDTH-1:0] rem_nxt  [1:WIDTH];
  logic [WIDTH-1:0] nq_nxt   [1:WIDTH];
  logic [WIDTH:0]   trial    [1:WIDTH];
  logic [WIDTH+1:0] diff     [1:WIDTH];

  // Output buffer: head register plus skid
  logic                         out_valid_r, out_valid_nxt;
  logic                         skid_full_r, skid_full_nxt;
  logic [i64dr_pkg::DATA_W-1:0] out_r, out_nxt;
  logic [i64dr_pkg::DATA_W-1:0] skid_r, skid_nxt;

  logic adv;
  logic push;
  logic pop;

  // Whole pipe advances unless a result is already parked in the skid
  assign adv      = !skid_full_r;
  assign in_ready = adv;
  assign push     = adv && v_r[WIDTH];
  assign pop      = out_valid_r && out_ready;

  // --------------------------------------------------------------------------
  // Magnitude stage
  // --------------------------------------------------------------------------
  logic [WIDTH-1:0] a_in, b_in, a_mag, b_mag;
  logic             is_signed, sel_rem, na, nb, neg_in;

  always_comb begin
    a_in      = in_dividend[WIDTH-1:0];
    b_in      = in_divisor[WIDTH-1:0];
    sel_rem   = (in_mode == i64dr_pkg::MODE_UREM) || (in_mode == i64dr_pkg::MODE_SREM);
    is_signed = (in_mode == i64dr_pkg::MODE_SQUO) || (in_mode == i64dr_pkg::MODE_SREM);
    na        = is_signed && a_in[WIDTH-1];
    nb        = is_signed && b_in[WIDTH-1];
    a_mag     = na ? (~a_in + WIDTH'(1)) : a_in;
    b_mag     = nb ? (~b_in + WIDTH'(1)) : b_in;
    // remainder follows the dividend sign, quotient the sign difference
    neg_in    = sel_rem ? na : (na ^ nb);
  end

  // --------------------------------------------------------------------------
  // Bit stages: shift in next dividend bit, trial subtract, restore on borrow.
  // With a zero divisor the trial always succeeds and the top bit falls off,
  // which leaves the dividend as remainder.
  // --------------------------------------------------------------------------
  always_comb begin
    for (int s = 1; s <= WIDTH; s++) begin
      trial[s] = {rem_r[s-1], nq_r[s-1][WIDTH-1]};
      diff[s]  = {1'b0, trial[s]} - {2'b00, d_r[s-1]};
      if (diff[s][WIDTH+1]) begin
        rem_nxt[s] = trial[s][WIDTH-1:0];
        nq_nxt[s]  = {nq_r[s-1][WIDTH-2:0], 1'b0};
      end else begin
        rem_nxt[s] = diff[s][WIDTH-1:0];
        nq_nxt[s]  = {nq_r[s-1][WIDTH-2:0], 1'b1};
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0]    <= '0;
      nq_r[0]     <= a_mag;
      d_r[0]      <= b_mag;
      selrem_r[0] <= sel_rem;
      neg_r[0]    <= neg_in;
      for (int s = 1; s <= WIDTH; s++) begin
        rem_r[s]    <= rem_nxt[s];
        nq_r[s]     <= nq_nxt[s];
        d_r[s]      <= d_r[s-1];
        selrem_r[s] <= selrem_r[s-1];
        neg_r[s]    <= neg_r[s-1];
      end
    end
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[WIDTH-1:0], in_valid};
    end
  end

  // --------------------------------------------------------------------------
  // Sign fix-up and output buffer
  // --------------------------------------------------------------------------
  logic [WIDTH-1:0] pick, fixed;

  always_comb begin
    pick  = selrem_r[WIDTH] ? rem_r[WIDTH] : nq_r[WIDTH];
    fixed = neg_r[WIDTH] ? (~pick + WIDTH'(1)) : pick;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    skid_full_nxt = skid_full_r;
    out_nxt       = out_r;
    skid_nxt      = skid_r;
    if (skid_full_r) begin
      if (pop) begin
        out_nxt       = skid_r;
        skid_full_nxt = 1'b0;
      end
    end else if (out_valid_r) begin
      if (push && pop) begin
        out_nxt = i64dr_pkg::DATA_W'(fixed);
      end else if (push) begin
        skid_nxt      = i64dr_pkg::DATA_W'(fixed);
        skid_full_nxt = 1'b1;
      end else if (pop) begin
        out_valid_nxt = 1'b0;
      end
    end else if (push) begin
      out_nxt       = i64dr_pkg::DATA_W'(fixed);
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_full_r <= skid_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_skid_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |-> out_valid_r)
    else $error("skid occupied with empty head");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v_r[0])
    else $error("accepted beat missing from magnitude stage");

  a_tail_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[WIDTH] && !skid_full_r) |=> out_valid_r)
    else $error("finished division not captured by output buffer");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[WIDTH] && (d_r[WIDTH] != '0)) |-> (rem_r[WIDTH] < d_r[WIDTH]))
    else $error("remainder not below divisor");

  a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[WIDTH] && (d_r[WIDTH] == '0)) |-> (nq_r[WIDTH] == '1))
    else $error("zero divisor quotient not all ones");

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for int64_divide_remainder. A directed table covers the
// extremes (zero divisor, most negative operand, all-ones patterns, sign
// mixes) and is followed by random divisions. Both channels idle at random,
// and one long output hold-off fills the pipe. Every result beat is compared
// in order with its typed-in result or a bit-exact restoring-division predictor.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Port width and working width of the divider under test (its default)
  localparam int unsigned DATA_W       = i64dr_pkg::DATA_W;
  localparam int unsigned CORE_W       = i64dr_pkg::DEF_WIDTH;
  localparam int          RESET_CYCLES = 11;
  localparam int          RANDOM_ITEMS = 400;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          IDLE_PCT     = 38;
  localparam int          CYCLE_LIMIT  = 200000;

  localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};
  localparam logic [DATA_W-1:0] NEG_MAX  = 64'h8000_0000_0000_0000;
  localparam logic [DATA_W-1:0] POS_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;

  // One row of the directed table; known rows carry the result typed in,
  // the rest are left to the predictor.
  typedef struct {
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
    i64dr_pkg::mode_t  mode;
    logic              known;
    logic [DATA_W-1:0] result;
  } division_row_t;

  // A division in flight, oldest at the front of the queue
  typedef struct {
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
    i64dr_pkg::mode_t  mode;
    logic [DATA_W-1:0] result;
  } pending_division_t;

  localparam int NUM_DIRECTED = 25;

  division_row_t directed_rows [NUM_DIRECTED] = '{
    // zero divisor: all-ones quotient, dividend as remainder, then sign fix-up
    '{64'd0, 64'd0, i64dr_pkg::MODE_UQUO, 1'b1, ALL_ONES},
    '{64'h0123_4567_89AB_CDEF, 64'd0, i64dr_pkg::MODE_UREM, 1'b1,
      64'h0123_4567_89AB_CDEF},
    '{64'd5, 64'd0, i64dr_pkg::MODE_SQUO, 1'b1, ALL_ONES},
    '{64'hFFFF_FFFF_FFFF_FFFB, 64'd0, i64dr_pkg::MODE_SQUO, 1'b1, 64'd1},
    '{64'hFFFF_FFFF_FFFF_FFFB, 64'd0, i64dr_pkg::MODE_SREM, 1'b1,
      64'hFFFF_FFFF_FFFF_FFFB},
    // most negative value is its own magnitude
    '{NEG_MAX,  ALL_ONES, i64dr_pkg::MODE_SQUO, 1'b1, NEG_MAX},
    '{NEG_MAX,  ALL_ONES, i64dr_pkg::MODE_SREM, 1'b1, 64'd0},
    '{NEG_MAX,  64'd1,    i64dr_pkg::MODE_SQUO, 1'b1, NEG_MAX},
    '{NEG_MAX,  64'd0,    i64dr_pkg::MODE_SREM, 1'b1, NEG_MAX},
    // all-ones patterns, unsigned
    '{ALL_ONES, ALL_ONES, i64dr_pkg::MODE_UQUO, 1'b1, 64'd1},
    '{ALL_ONES, 64'd1,    i64dr_pkg::MODE_UQUO, 1'b1, ALL_ONES},
    '{ALL_ONES, 64'd1,    i64dr_pkg::MODE_UREM, 1'b1, 64'd0},
    '{64'd1,    ALL_ONES, i64dr_pkg::MODE_UQUO, 1'b1, 64'd0},
    '{64'd1,    ALL_ONES, i64dr_pkg::MODE_UREM, 1'b1, 64'd1},
    // truncation toward zero, every sign mix
    '{64'hFFFF_FFFF_FFFF_FFF9, 64'd2, i64dr_pkg::MODE_SQUO, 1'b1,
      64'hFFFF_FFFF_FFFF_FFFD},
    '{64'hFFFF_FFFF_FFFF_FFF9, 64'd2, i64dr_pkg::MODE_SREM, 1'b1, ALL_ONES},
    '{64'd7, 64'hFFFF_FFFF_FFFF_FFFE, i64dr_pkg::MODE_SQUO, 1'b1,
      64'hFFFF_FFFF_FFFF_FFFD},
    '{64'd7, 64'hFFFF_FFFF_FFFF_FFFE, i64dr_pkg::MODE_SREM, 1'b1, 64'd1},
    '{POS_MAX,  NEG_MAX,  i64dr_pkg::MODE_UQUO, 1'b1, 64'd0},
    '{NEG_MAX,  POS_MAX,  i64dr_pkg::MODE_UREM, 1'b1, 64'd1},
    // ordinary operands, predictor only
    '{64'hDEAD_BEEF_0123_4567, 64'h0000_0000_0001_2345, i64dr_pkg::MODE_UQUO,
      1'b0, 64'd0},
    '{64'hDEAD_BEEF_0123_4567, 64'h0000_0000_0001_2345, i64dr_pkg::MODE_UREM,
      1'b0, 64'd0},
    '{64'h8765_4321_0FED_CBA9, 64'hFFFF_FFFF_FFF0_1234, i64dr_pkg::MODE_SQUO,
      1'b0, 64'd0},
    '{64'h8765_4321_0FED_CBA9, 64'hFFFF_FFFF_FFF0_1234, i64dr_pkg::MODE_SREM,
      1'b0, 64'd0},
    '{POS_MAX,  64'd3,    i64dr_pkg::MODE_SREM, 1'b0, 64'd0}
  };

  // DUT-facing signals; the DUT's inputs are all known from time zero
  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              in_valid     = 1'b0;
  logic              in_ready;
  logic [DATA_W-1:0] in_dividend  = '0;
  logic [DATA_W-1:0] in_divisor   = '0;
  i64dr_pkg::mode_t  in_mode      = i64dr_pkg::MODE_UQUO;
  logic              out_valid;
  logic              out_ready    = 1'b0;
  logic [DATA_W-1:0] out_result;

  // Traffic shaping, written by the stimulus process only
  logic sender_idles   = 1'b1;
  logic receiver_idles = 1'b1;
  logic hold_off_go    = 1'b0;

  pending_division_t pending_divisions [$];
  int                mismatches  = 0;
  int                cycle_count = 0;

  int64_divide_remainder #(
    .WIDTH (CORE_W)
  ) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_dividend (in_dividend),
    .in_divisor  (in_divisor),
    .in_mode     (in_mode),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_result  (out_result)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Restoring division on magnitudes, MSB first, with a WIDTH+1 bit partial
  // remainder so the trial subtract never overflows. Signed modes negate the
  // quotient on differing signs and give the remainder the dividend's sign.
  function automatic logic [DATA_W-1:0] predict_divide(
    input logic [DATA_W-1:0] dividend,
    input logic [DATA_W-1:0] divisor,
    input i64dr_pkg::mode_t  mode
  );
    logic [DATA_W-1:0] wmask;
    logic [DATA_W-1:0] num;
    logic [DATA_W-1:0] den;
    logic [DATA_W-1:0] quo;
    logic [DATA_W-1:0] res;
    logic [DATA_W:0]   part;
    logic              is_signed;
    logic              num_neg;
    logic              den_neg;
    wmask     = ALL_ONES >> (DATA_W - CORE_W);
    num       = dividend & wmask;
    den       = divisor & wmask;
    is_signed = (mode == i64dr_pkg::MODE_SQUO) || (mode == i64dr_pkg::MODE_SREM);
    num_neg   = is_signed && num[CORE_W-1];
    den_neg   = is_signed && den[CORE_W-1];
    if (num_neg) num = (-num) & wmask;
    if (den_neg) den = (-den) & wmask;
    quo  = '0;
    part = '0;
    for (int i = CORE_W - 1; i >= 0; i--) begin
      part = {part[DATA_W-1:0], num[i]};
      if (part >= {1'b0, den}) begin
        part   = part - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    case (mode)
      i64dr_pkg::MODE_UQUO: begin
        res = quo;
      end
      i64dr_pkg::MODE_UREM: begin
        res = part[DATA_W-1:0];
      end
      i64dr_pkg::MODE_SQUO: begin
        res = (num_neg != den_neg) ? -quo : quo;
      end
      default: begin
        res = num_neg ? -part[DATA_W-1:0] : part[DATA_W-1:0];
      end
    endcase
    return res & wmask;
  endfunction

  // Operand classes: extremes, small magnitudes of either sign, a random
  // value cut down to a random length, or a full random pattern.
  function automatic logic [DATA_W-1:0] random_operand();
    logic [DATA_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0:       v = '0;
          1:       v = 64'd1;
          2:       v = ALL_ONES;
          3:       v = NEG_MAX;
          default: v = POS_MAX;
        endcase
      end
      1, 2: begin
        v = DATA_W'($urandom_range(15));
        if ($urandom_range(1)) v = -v;
      end
      3, 4: begin
        v = v >> $urandom_range(63);
      end
      default: begin
      end
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatches++;
  endtask

  // Offer one division beat; optional idle cycles go first, then valid is
  // held with a steady payload until the beat is taken.
  task automatic offer_division(
    input logic [DATA_W-1:0] dividend,
    input logic [DATA_W-1:0] divisor,
    input i64dr_pkg::mode_t  mode,
    input logic              known,
    input logic [DATA_W-1:0] known_result
  );
    int                idle;
    pending_division_t entry;
    idle = 0;
    if (sender_idles) begin
      while (($urandom_range(99) < IDLE_PCT) && (idle < 8)) idle++;
    end
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_dividend <= dividend;
    in_divisor  <= divisor;
    in_mode     <= mode;
    entry.dividend = dividend;
    entry.divisor  = divisor;
    entry.mode     = mode;
    entry.result   = known ? known_result : predict_divide(dividend, divisor, mode);
    do @(posedge clk); while (!in_ready);
    pending_divisions.push_back(entry);
  endtask

  // Result side: random back-pressure, and once asked a long hold-off that
  // outlasts the pipe depth so in_ready has to drop.
  initial begin
    int hold_left;
    hold_left = HOLD_CYCLES;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ready <= 1'b0;
      end else if (hold_off_go && (hold_left > 0)) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!receiver_idles) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Result checker: each accepted beat against the oldest pending division
  always @(posedge clk) begin
    pending_division_t head;
    if (rst_n && out_valid && out_ready) begin
      if (pending_divisions.size() == 0) begin
        report_mismatch($sformatf("result %h with no division outstanding", out_result));
      end else begin
        head = pending_divisions.pop_front();
        if (out_result !== head.result)
          report_mismatch($sformatf("%h / %h %s: result %h, expected %h",
                                    head.dividend, head.divisor, head.mode.name(),
                                    out_result, head.result));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stimulus: reset, directed table, then random divisions in phases
  initial begin
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[k])
      offer_division(directed_rows[k].dividend, directed_rows[k].divisor,
                     directed_rows[k].mode, directed_rows[k].known,
                     directed_rows[k].result);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // back-to-back stretch with no idling on either side
      if (n == 100) begin
        sender_idles   <= 1'b0;
        receiver_idles <= 1'b0;
      end
      if (n == 180) begin
        sender_idles   <= 1'b1;
        receiver_idles <= 1'b1;
      end
      // output hold-off while the sender keeps pushing: pipe fills and stalls
      if (n == 200) begin
        sender_idles <= 1'b0;
        hold_off_go  <= 1'b1;
      end
      if (n == 300) sender_idles <= 1'b1;

      a = random_operand();
      b = random_operand();
      // divisor derived from a shifted dividend exercises long quotients
      if ($urandom_range(7) == 0)
        b = (a >> $urandom_range(63)) ^ DATA_W'($urandom_range(3));
      offer_division(a, b, i64dr_pkg::mode_t'($urandom_range(3)), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_divisions.size() != 0) @(posedge clk);
    // let any stray beat surface before the verdict
    repeat (CORE_W + 8) @(posedge clk);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
